// ----- rtl/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;
   localparam int OperandWidth = 32;
   localparam int ProdWidth = 64;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // divider operand selection
   typedef enum logic [1:0] {
      SEL_MOD = 2'd0, // x mod y
      SEL_NUM = 2'd1, // num / g
      SEL_DEN = 2'd2  // den / g
   } div_sel_type;

   // datapath commands from the controller
   typedef struct packed {
      logic load;      // capture operands, start product phase
      logic mul_step;  // next partial product
      logic div_start; // start a serial divide
      logic div_step;  // one quotient bit
      logic gcd_swap;  // x <= y, y <= remainder
      logic reduce_num; // num <= quotient
      logic reduce_den; // den <= quotient
      div_sel_type div_sel;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic y_zero;
      logic num_zero;
      logic dz;
      logic g_gt1;
   } sts_type;
endpackage

// ----- rtl/rational_arithmetic_unit_core.sv -----
// Rational arithmetic unit top level.
// One word at a time: cross products are formed on one shared multiplier, then each
// Euclid step is a 64-bit serial divide, and a reduction (when the gcd exceeds one)
// adds two more such divides. The next word is taken once the result has been taken.
// Division by a zero fraction gives 0/1 with div_by_zero set.
module rational_arithmetic_unit_core #(
   parameter int OPERAND_WIDTH = rau_pkg::OperandWidth
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // operation[1:0], a_num[33:2], a_den[64:34], b_num[96:65], b_den[127:97]
   input  logic [127:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // result_num[63:0], result_den[126:64], zero fill
   output logic [127:0] rsp_tdata,
   // div_by_zero
   output logic rsp_tuser
);
   import rau_pkg::*;
   cmd_type cmd;
   sts_type sts;
   logic zero, dz;
   logic [63:0] rn;
   logic [62:0] rd;

   rau_ctrl u_ctrl (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_zero(zero), .out_dz(dz),
      .cmd, .sts
   );

   rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
      .clock, .reset, .cmd, .sts, .op(req_tdata[1:0]),
      .a_num(req_tdata[2 +: OPERAND_WIDTH]),
      .a_den(req_tdata[34 +: OPERAND_WIDTH-1]),
      .b_num(req_tdata[65 +: OPERAND_WIDTH]),
      .b_den(req_tdata[97 +: OPERAND_WIDTH-1]),
      .res_num(rn), .res_den(rd)
   );

   assign rsp_tdata = {1'b0, zero ? 63'd1 : rd, zero ? 64'd0 : rn};
   assign rsp_tuser = dz;
endmodule

// ----- rtl/rau_datapath.sv -----
// Datapath: serial cross products, serial divider, gcd registers.
module rau_datapath #(
   parameter int OPERAND_WIDTH = rau_pkg::OperandWidth
) (
   input  logic clock,
   input  logic reset,
   input  rau_pkg::cmd_type cmd,
   output rau_pkg::sts_type sts,
   input  logic [1:0] op,
   input  logic [OPERAND_WIDTH-1:0] a_num,
   input  logic [OPERAND_WIDTH-2:0] a_den,
   input  logic [OPERAND_WIDTH-1:0] b_num,
   input  logic [OPERAND_WIDTH-2:0] b_den,
   output logic [63:0] res_num,
   output logic [62:0] res_den
);
   import rau_pkg::*;
   localparam int W = OPERAND_WIDTH;

   logic signed [W-1:0] an_ff, bn_ff;
   logic signed [W:0] ad_ff, bd_ff;
   logic [1:0] op_ff;
   logic [1:0] mcnt_ff;
   logic signed [63:0] n_ff, n_in, d_ff;
   logic signed [63:0] p0_ff, p1_ff;
   logic neg_ff;
   logic [63:0] un_ff, ud_ff, x_ff, y_ff;
   logic [63:0] q_ff, r_ff, dvd_ff, dvs_ff;
   logic [6:0] dcnt_ff;
   logic dbusy_ff;
   logic signed [W:0] ma, mb;
   logic signed [2*W+1:0] prod;
   logic [64:0] rtry;

   // one multiply per step; registered product feeds the next step
   always_comb begin
      ma = '0; mb = '0;
      case (mcnt_ff)
         2'd0: begin
            ma = {an_ff[W-1], an_ff};
            mb = (op_ff == OP_MUL) ? {bn_ff[W-1], bn_ff} : bd_ff;
         end
         2'd1: begin
            ma = {bn_ff[W-1], bn_ff};
            mb = ad_ff;
         end
         default: begin
            ma = ad_ff;
            mb = (op_ff == OP_DIV) ? {bn_ff[W-1], bn_ff} : bd_ff;
         end
      endcase
      prod = ma * mb;
   end

   assign rtry = {r_ff, dvd_ff[63]} - {1'b0, dvs_ff};

   always_comb begin
      n_in = n_ff;
      case (op_ff)
         OP_ADD: n_in = p0_ff + p1_ff;
         OP_SUB: n_in = p0_ff - p1_ff;
         default: n_in = p0_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mcnt_ff <= '0;
         dbusy_ff <= 1'b0;
         dcnt_ff <= '0;
      end else begin
         if (cmd.load) begin
            op_ff <= op;
            an_ff <= a_num;
            bn_ff <= b_num;
            ad_ff <= {2'b0, a_den};
            bd_ff <= {2'b0, b_den};
            mcnt_ff <= '0;
         end else if (cmd.mul_step) begin
            case (mcnt_ff)
               2'd0: p0_ff <= 64'(prod);
               2'd1: p1_ff <= 64'(prod);
               2'd2: d_ff <= 64'(prod);
               default: begin
                  n_ff <= n_in;
                  neg_ff <= n_in[63] ^ d_ff[63];
                  un_ff <= n_in[63] ? 64'd0 - n_in : n_in;
                  ud_ff <= d_ff[63] ? 64'd0 - d_ff : d_ff;
                  x_ff <= n_in[63] ? 64'd0 - n_in : n_in;
                  y_ff <= d_ff[63] ? 64'd0 - d_ff : d_ff;
               end
            endcase
            mcnt_ff <= mcnt_ff + 2'd1;
         end
         if (cmd.div_start) begin
            case (cmd.div_sel)
               SEL_MOD: begin dvd_ff <= x_ff; dvs_ff <= y_ff; end
               SEL_NUM: begin dvd_ff <= un_ff; dvs_ff <= x_ff; end
               default: begin dvd_ff <= ud_ff; dvs_ff <= x_ff; end
            endcase
            r_ff <= '0;
            q_ff <= '0;
            dcnt_ff <= '0;
            dbusy_ff <= 1'b1;
         end else if (cmd.div_step && dbusy_ff) begin
            // restoring divide, one bit per cycle
            if (!rtry[64]) begin
               r_ff <= rtry[63:0];
               q_ff <= {q_ff[62:0], 1'b1};
            end else begin
               r_ff <= {r_ff[62:0], dvd_ff[63]};
               q_ff <= {q_ff[62:0], 1'b0};
            end
            dvd_ff <= {dvd_ff[62:0], 1'b0};
            dcnt_ff <= dcnt_ff + 7'd1;
            if (dcnt_ff == 7'd63) dbusy_ff <= 1'b0;
         end
         if (cmd.gcd_swap) begin
            x_ff <= y_ff;
            y_ff <= r_ff;
         end
         if (cmd.reduce_num) un_ff <= q_ff;
         if (cmd.reduce_den) ud_ff <= q_ff;
      end
   end

   assign sts.mul_done = (mcnt_ff == 2'd3);
   assign sts.div_done = !dbusy_ff;
   assign sts.y_zero = (y_ff == '0);
   assign sts.num_zero = (n_ff == '0);
   assign sts.dz = (op_ff == OP_DIV) && (bn_ff == '0);
   assign sts.g_gt1 = (x_ff > 64'd1);
   assign res_num = neg_ff ? 64'd0 - un_ff : un_ff;
   assign res_den = ud_ff[62:0];
endmodule

// ----- rtl/rau_ctrl.sv -----
// Controller: sequences products, gcd loop and reduction divides.
module rau_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   output logic out_valid,
   input  logic out_ready,
   output logic out_zero,
   output logic out_dz,
   output rau_pkg::cmd_type cmd,
   input  rau_pkg::sts_type sts
);
   import rau_pkg::*;
   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_CHK, S_GCD, S_GWAIT, S_RN, S_RNW, S_RD, S_RDW, S_OUT
   } state_type;
   state_type state_ff;
   logic zero_ff, dz_ff;
   logic started_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: cmd.load = in_valid;
         // the last step (count 3) forms the numerator and the gcd operands
         S_MUL: cmd.mul_step = 1'b1;
         S_GCD: begin cmd.div_start = !sts.y_zero; cmd.div_sel = SEL_MOD; end
         S_GWAIT: begin
            cmd.div_step = 1'b1;
            cmd.gcd_swap = sts.div_done && started_ff;
         end
         S_RN: begin cmd.div_start = 1'b1; cmd.div_sel = SEL_NUM; end
         S_RNW: begin
            cmd.div_step = 1'b1;
            cmd.reduce_num = sts.div_done && started_ff;
         end
         S_RD: begin cmd.div_start = 1'b1; cmd.div_sel = SEL_DEN; end
         S_RDW: begin
            cmd.div_step = 1'b1;
            cmd.reduce_den = sts.div_done && started_ff;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         zero_ff <= 1'b0;
         dz_ff <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (in_valid) state_ff <= S_MUL;
            S_MUL: if (sts.mul_done) begin
               state_ff <= S_CHK;
            end
            S_CHK: begin
               dz_ff <= sts.dz;
               zero_ff <= sts.dz || sts.num_zero;
               state_ff <= (sts.dz || sts.num_zero) ? S_OUT : S_GCD;
            end
            S_GCD: begin
               started_ff <= 1'b0;
               state_ff <= sts.y_zero ? (sts.g_gt1 ? S_RN : S_OUT) : S_GWAIT;
            end
            S_GWAIT, S_RNW, S_RDW: begin
               // div_done already reads busy in the cycle after a start; started_ff is an extra guard
               started_ff <= 1'b1;
               if (sts.div_done && started_ff) begin
                  started_ff <= 1'b0;
                  case (state_ff)
                     S_GWAIT: state_ff <= S_GCD;
                     S_RNW: state_ff <= S_RD;
                     default: state_ff <= S_OUT;
                  endcase
               end
            end
            S_RN: state_ff <= S_RNW;
            S_RD: state_ff <= S_RDW;
            S_OUT: if (out_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);
   assign out_zero = zero_ff;
   assign out_dz = dz_ff;
endmodule

// ----- rtl/rau_checker.sv -----
// Port-level checks for the rational arithmetic unit.
module rau_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic rsp_tuser
);
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("overlap");
   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[63:0] == 64'd0) else $error("dz");
   a_den: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[63:0] == 64'd0 |-> rsp_tdata[126:64] == 63'd1) else $error("den");
endmodule

bind rational_arithmetic_unit_core rau_checker u_chk (.*);

// ----- tb/tb_rational_arithmetic_unit_core.sv -----
// Self-checking testbench for the rational arithmetic unit core.
module tb_rational_arithmetic_unit_core;
   import rau_pkg::*;

   typedef struct {
      bit [62:0] den;
      longint num;
      bit dz;
   } fraction_result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [127:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [127:0] rsp_tdata;
   logic rsp_tuser;

   fraction_result_type pending_results[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int holdoff_cycles = 0;

   rational_arithmetic_unit_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400000000;
      $display("simulation failed");
      $finish;
   end

   // exact fraction arithmetic, reduced with Euclid
   function automatic fraction_result_type reduce_fraction(logic [127:0] word);
      fraction_result_type r;
      op_type op;
      longint an, ad, bn, bd, n, d;
      bit [63:0] un, ud, x, y, t;
      bit neg;
      op = op_type'(word[1:0]);
      an = longint'($signed(word[33:2]));
      ad = longint'({1'b0, word[64:34]});
      bn = longint'($signed(word[96:65]));
      bd = longint'({1'b0, word[127:97]});
      r.num = 0;
      r.den = 63'd1;
      r.dz = 1'b0;
      if (op == OP_DIV && bn == 0) begin
         r.dz = 1'b1;
         return r;
      end
      case (op)
         OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
         OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
         OP_MUL: begin n = an * bn; d = ad * bd; end
         default: begin n = an * bd; d = ad * bn; end
      endcase
      if (n == 0) return r;
      neg = n < 0;
      un = neg ? -n : n;
      if (d < 0) begin
         neg = !neg;
         ud = -d;
      end else begin
         ud = d;
      end
      x = un;
      y = ud;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      if (x > 1) begin
         un = un / x;
         ud = ud / x;
      end
      r.num = neg ? -un : un;
      r.den = ud[62:0];
      return r;
   endfunction

   // receiver: random stalls, or a counted hold-off
   always @(negedge clock) begin
      if (holdoff_cycles > 0) begin
         rsp_tready <= 1'b0;
         holdoff_cycles <= holdoff_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      fraction_result_type e;
      if (!reset && req_tvalid && req_tready) pending_results.push_back(reduce_fraction(req_tdata));
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result word with no expectation pending");
            error_count++;
         end else begin
            e = pending_results.pop_front();
            if ($signed(rsp_tdata[63:0]) != e.num) begin
               $error("result_num expected %0d actual %0d", e.num, $signed(rsp_tdata[63:0]));
               error_count++;
            end
            if (rsp_tdata[126:64] != e.den) begin
               $error("result_den expected %0d actual %0d", e.den, rsp_tdata[126:64]);
               error_count++;
            end
            if (rsp_tuser != e.dz) begin
               $error("div_by_zero expected %0d actual %0d", e.dz, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   task automatic send_word(op_type op, logic [31:0] an, logic [30:0] ad,
                            logic [31:0] bn, logic [30:0] bd);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = {bd, bn, ad, an, op};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random;
      logic [31:0] an, bn;
      logic [30:0] ad, bd;
      if ($urandom_range(99) < 60) begin
         an = 32'($urandom_range(2000)) - 32'd1000;
         bn = 32'($urandom_range(2000)) - 32'd1000;
         ad = 31'($urandom_range(1000, 1));
         bd = 31'($urandom_range(1000, 1));
      end else begin
         an = $urandom;
         bn = $urandom;
         ad = 31'($urandom);
         bd = 31'($urandom);
         if (ad == 0) ad = 31'd1;
         if (bd == 0) bd = 31'd1;
      end
      if ($urandom_range(99) < 5) bn = 32'd0;
      if ($urandom_range(99) < 2) ad = 31'd0;
      if ($urandom_range(99) < 2) bd = 31'd0;
      send_word(op_type'($urandom_range(3)), an, ad, bn, bd);
   endtask

   task automatic drain_results;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed;
      send_word(OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
      send_word(OP_SUB, 32'd1, 31'd2, 32'd1, 31'd2);
      send_word(OP_MUL, -32'sd4, 31'd6, 32'd3, 31'd8);
      send_word(OP_DIV, 32'd3, 31'd4, -32'sd9, 31'd8);
      send_word(OP_DIV, 32'd5, 31'd7, 32'd0, 31'd3);
      send_word(OP_DIV, 32'd0, 31'd7, 32'd0, 31'd1);
      send_word(OP_MUL, 32'd0, 31'd5, 32'd9, 31'd4);
      send_word(OP_ADD, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
      send_word(OP_SUB, 32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
      send_word(OP_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
      send_word(OP_MUL, 32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
      send_word(OP_DIV, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'h7fff_ffff);
      send_word(OP_DIV, 32'h7fff_ffff, 31'd1, 32'h8000_0000, 31'd1);
      send_word(OP_ADD, 32'd6, 31'd0, 32'd4, 31'd3);  // zero denominator
      send_word(OP_MUL, -32'sd6, 31'd0, 32'd4, 31'd0);
      send_word(OP_ADD, 32'd0, 31'd0, 32'd0, 31'd5);
      send_word(OP_SUB, -32'sd1, 31'd1, 32'd1, 31'd1);
      send_word(OP_ADD, 32'h5555_5555, 31'h2aaa_aaaa, 32'haaaa_aaaa, 31'h5555_5555);
      send_word(OP_DIV, 32'd1, 31'd1, 32'd1, 31'd1);
      drain_results();
   endtask

   task automatic test_random_phase(int idle_pct, int stall_pct, int count);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_random();
      drain_results();
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      @(negedge clock);
      holdoff_cycles = 4000;
      repeat (20) send_random();
      drain_results();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_phase(0, 0, 150);
      test_random_phase(50, 0, 150);
      test_random_phase(0, 50, 150);
      test_random_phase(34, 34, 150);
      test_backpressure();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
